@@ rtl/dero_pkg.sv @@
// types, constants and register codes for the delta escape row decoder
package dero_pkg;

    localparam int unsigned WIDTH_BITS = 15;
    localparam int unsigned PIX_BITS   = 16;
    localparam int unsigned BYTE_BITS  = 8;

    localparam logic [WIDTH_BITS-1:0] RESET_ROW_WIDTH = 15'd512;
    localparam logic [BYTE_BITS-1:0]  ESCAPE_CODE     = 8'h80;

    // configuration register indexes
    localparam logic CFG_ROW_WIDTH  = 1'b0;
    localparam logic CFG_BIG_ENDIAN = 1'b1;

    typedef enum logic [7:0] {
        PH_CNT0 = 8'b0000_0001,
        PH_CNT1 = 8'b0000_0010,
        PH_PIX0 = 8'b0000_0100,
        PH_PIX1 = 8'b0000_1000,
        PH_CODE = 8'b0001_0000,
        PH_LIT0 = 8'b0010_0000,
        PH_LIT1 = 8'b0100_0000,
        PH_SKIP = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [PIX_BITS-1:0]   bytes_remaining;
        logic [WIDTH_BITS-1:0] pixels_done;
        logic [PIX_BITS-1:0]   current_pixel;
        logic [BYTE_BITS-1:0]  held_byte;
        logic                  raw_mode;
    } t_state;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_value;
        logic                last_of_row;
        logic                short_row;
    } t_res;

    localparam t_state STATE_RESET = '{
        phase:           PH_CNT0,
        bytes_remaining: '0,
        pixels_done:     '0,
        current_pixel:   '0,
        held_byte:       '0,
        raw_mode:        1'b0
    };

endpackage

@@ rtl/delta_escape_row_decoder.sv @@
// top level: input word register, row decode step and result register
// an accepted byte passes from the input word register through the decode step into the result register
// throughput: one byte per cycle, limited only by the result register draining
// the decode state is updated in a single pass per byte between the two registers
// reset (synchronous, active low): awaiting the first count byte, width 512,
// little-endian order, both registers empty
module delta_escape_row_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [dero_pkg::WIDTH_BITS-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dero_pkg::BYTE_BITS-1:0]      i_in_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dero_pkg::PIX_BITS-1:0]       o_pixel_value,
    output logic                                o_last_of_row,
    output logic                                o_short_row
);

    logic [dero_pkg::WIDTH_BITS-1:0] r_row_width;
    logic                            r_big_endian;
    logic                            r_in_valid;
    logic [dero_pkg::BYTE_BITS-1:0]  r_in_byte;
    logic                            r_out_valid;
    dero_pkg::t_res                  r_out;
    dero_pkg::t_state                r_state;
    dero_pkg::t_state                n_state;
    dero_pkg::t_res                  n_out;
    logic                            n_out_valid;
    logic                            proc;

    assign proc       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;

    dero_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_row_width  (r_row_width),
        .i_big_endian (r_big_endian),
        .o_state      (n_state),
        .o_res_valid  (n_out_valid),
        .o_res        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= dero_pkg::RESET_ROW_WIDTH;
            r_big_endian <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dero_pkg::CFG_ROW_WIDTH:  r_row_width  <= i_cfg_data;
                dero_pkg::CFG_BIG_ENDIAN: r_big_endian <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dero_pkg::STATE_RESET;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= n_out_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_out.pixel_value;
    assign o_last_of_row = r_out.last_of_row;
    assign o_short_row   = r_out.short_row;

endmodule

@@ rtl/dero_step.sv @@
// next-state and result logic for one byte of the row stream
module dero_step (
    input  dero_pkg::t_state                  i_state,
    input  logic [dero_pkg::BYTE_BITS-1:0]    i_byte,
    input  logic [dero_pkg::WIDTH_BITS-1:0]   i_row_width,
    input  logic                              i_big_endian,
    output dero_pkg::t_state                  o_state,
    output logic                              o_res_valid,
    output dero_pkg::t_res                    o_res
);

    logic [dero_pkg::PIX_BITS-1:0]   joined;
    logic [dero_pkg::PIX_BITS-1:0]   rem_dec;
    logic [dero_pkg::WIDTH_BITS-1:0] pd_inc;
    logic                            have;
    logic                            data_byte;

    assign joined  = i_big_endian ? {i_state.held_byte, i_byte} : {i_byte, i_state.held_byte};
    assign rem_dec = i_state.bytes_remaining - 16'd1;
    assign pd_inc  = i_state.pixels_done + 15'd1;

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        have        = 1'b0;
        data_byte   = 1'b0;

        case (i_state.phase)
            dero_pkg::PH_CNT0: begin
                o_state.held_byte = i_byte;
                o_state.phase     = dero_pkg::PH_CNT1;
            end
            dero_pkg::PH_CNT1: begin
                o_state.bytes_remaining = joined;
                o_state.pixels_done     = '0;
                o_state.raw_mode        = (joined == {i_row_width, 1'b0});
                if (i_row_width == '0) begin
                    o_state.phase = (joined != '0) ? dero_pkg::PH_SKIP : dero_pkg::PH_CNT0;
                end else if (joined == '0) begin
                    o_state.phase     = dero_pkg::PH_CNT0;
                    o_res_valid       = 1'b1;
                    o_res.last_of_row = 1'b1;
                    o_res.short_row   = 1'b1;
                end else begin
                    o_state.phase = dero_pkg::PH_PIX0;
                end
            end
            dero_pkg::PH_SKIP: begin
                o_state.bytes_remaining = rem_dec;
                if (rem_dec == '0) begin
                    o_state.phase = dero_pkg::PH_CNT0;
                end
            end
            dero_pkg::PH_PIX0: begin
                data_byte         = 1'b1;
                o_state.held_byte = i_byte;
                o_state.phase     = dero_pkg::PH_PIX1;
            end
            dero_pkg::PH_LIT0: begin
                data_byte         = 1'b1;
                o_state.held_byte = i_byte;
                o_state.phase     = dero_pkg::PH_LIT1;
            end
            dero_pkg::PH_PIX1: begin
                data_byte             = 1'b1;
                have                  = 1'b1;
                o_state.current_pixel = joined;
                o_state.phase = i_state.raw_mode ? dero_pkg::PH_PIX0 : dero_pkg::PH_CODE;
            end
            dero_pkg::PH_LIT1: begin
                data_byte             = 1'b1;
                have                  = 1'b1;
                o_state.current_pixel = joined;
                o_state.phase         = dero_pkg::PH_CODE;
            end
            dero_pkg::PH_CODE: begin
                data_byte = 1'b1;
                if (i_byte == dero_pkg::ESCAPE_CODE) begin
                    o_state.phase = dero_pkg::PH_LIT0;
                end else begin
                    have                  = 1'b1;
                    o_state.current_pixel = i_state.current_pixel
                                            + {{8{i_byte[7]}}, i_byte};
                end
            end
            default: begin
                o_state.phase = dero_pkg::PH_CNT0;
            end
        endcase

        if (data_byte) begin
            o_state.bytes_remaining = rem_dec;
            if (have) begin
                o_state.pixels_done = pd_inc;
            end
            if (have && (pd_inc >= i_row_width)) begin
                o_state.phase     = (rem_dec != '0) ? dero_pkg::PH_SKIP : dero_pkg::PH_CNT0;
                o_res_valid       = 1'b1;
                o_res.pixel_value = o_state.current_pixel;
                o_res.last_of_row = 1'b1;
            end else if (rem_dec == '0) begin
                o_state.phase     = dero_pkg::PH_CNT0;
                o_res_valid       = 1'b1;
                o_res.last_of_row = 1'b1;
                o_res.short_row   = 1'b1;
            end else if (have) begin
                o_res_valid       = 1'b1;
                o_res.pixel_value = o_state.current_pixel;
            end
        end
    end

endmodule

@@ rtl/dero_checker.sv @@
// port checker for the delta escape row decoder, bound to the top level
module dero_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [dero_pkg::PIX_BITS-1:0]       o_pixel_value,
    input  logic                                o_last_of_row,
    input  logic                                o_short_row
);

    // short-row word is a zero pixel that closes the row
    a_short_closes_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_short_row |-> o_last_of_row && (o_pixel_value == '0))
        else $error("short-row word not marked last or pixel not zero");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_value)
            && $stable(o_last_of_row) && $stable(o_short_row))
        else $error("stalled result word changed");

    // reset empties both sides
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // a fresh result word has an accepted input word behind it
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result word with no input word behind it");

endmodule

bind delta_escape_row_decoder dero_checker u_dero_checker (.*);
